// ===== hdl/ptp_pkg.sv =====
// Package for the page translation block: field widths, codes and the
// command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package ptp_pkg;

  // Field widths
  localparam int VADDR_W   = 32;
  localparam int PN_W      = 20;
  localparam int OFF_W     = 12;
  localparam int SLOT_W    = 4;
  localparam int KIND_W    = 2;
  localparam int FAULT_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int RIGHTS_W  = 4;

  // Rights bits inside a stored entry
  localparam int RB_VALID = 0;
  localparam int RB_READ  = 1;
  localparam int RB_WRITE = 2;
  localparam int RB_EXEC  = 3;

  // Item actions
  localparam logic ACT_TRANSLATE = 1'b0;
  localparam logic ACT_WRITE     = 1'b1;

  // Access kinds (anything else is checked as a read)
  localparam logic [KIND_W-1:0] ACC_READ  = 2'd0;
  localparam logic [KIND_W-1:0] ACC_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] ACC_FETCH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VM_ENABLED     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ATTACHED = 1'b1;

  // Fault codes, in check order
  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE      = 3'd0,
    FAULT_NO_MAP    = 3'd1,
    FAULT_INVALID   = 3'd2,
    FAULT_EXEC      = 3'd3,
    FAULT_WRITE     = 3'd4,
    FAULT_READ      = 3'd5
  } fault_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;  // input channel may take a word
    logic load;      // capture the input word
    logic match;     // compare all slots, perform slot write
    logic select;    // pick lowest hit, read its entry
    logic finish;    // form result, update marks, load output
  } ptp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;  // input word offered
    logic out_free;  // output register can take a word this cycle
  } ptp_status_t;

endpackage

`default_nettype wire

// ===== hdl/ptp_ifs.sv =====
// Channel interfaces of the page translation block: request, response and
// configuration write. Depends on ptp_pkg.
`default_nettype none

interface ptp_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [ptp_pkg::VADDR_W-1:0] vaddr;
  logic [ptp_pkg::KIND_W-1:0]  access_kind;
  logic [ptp_pkg::SLOT_W-1:0]  slot;
  logic                        entry_present;
  logic [ptp_pkg::PN_W-1:0]    entry_vpn;
  logic [ptp_pkg::PN_W-1:0]    entry_ppn;
  logic                        entry_valid;
  logic                        can_read;
  logic                        can_write;
  logic                        can_execute;

  modport source (
    output valid, action, vaddr, access_kind, slot, entry_present, entry_vpn,
           entry_ppn, entry_valid, can_read, can_write, can_execute,
    input  ready
  );
  modport sink (
    input  valid, action, vaddr, access_kind, slot, entry_present, entry_vpn,
           entry_ppn, entry_valid, can_read, can_write, can_execute,
    output ready
  );
endinterface

interface ptp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ptp_pkg::VADDR_W-1:0] paddr;
  logic [ptp_pkg::FAULT_W-1:0] fault_code;
  logic                        referenced_mark;
  logic                        dirty_mark;

  modport source (
    output valid, paddr, fault_code, referenced_mark, dirty_mark,
    input  ready
  );
  modport sink (
    input  valid, paddr, fault_code, referenced_mark, dirty_mark,
    output ready
  );
endinterface

interface ptp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ptp_pkg::CFG_IDX_W-1:0] index;
  logic                          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ptp_ctrl.sv =====
// Controller of the page translation block: steps each word through
// compare, select and finish. Depends on ptp_pkg.
`default_nettype none

module ptp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ptp_pkg::ptp_status_t status,
  output ptp_pkg::ptp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MATCH  = 4'b0010,
    S_SELECT = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_SELECT;
      end
      S_SELECT: begin
        cmd.select = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold here while the output register is occupied
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ptp_datapath.sv =====
// Datapath of the page translation block: config registers, slot table,
// compare lanes, hit select, permission checks and output register.
// Depends on ptp_pkg and the channel interfaces in ptp_ifs.
`default_nettype none

module ptp_datapath #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  ptp_req_if.sink            req,
  ptp_rsp_if.source          rsp,
  ptp_cfg_if.sink            cfg,
  input  wire ptp_pkg::ptp_cmd_t cmd,
  output ptp_pkg::ptp_status_t   status
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CMP_W = ((IDX_W > ptp_pkg::SLOT_W) ? IDX_W : ptp_pkg::SLOT_W) + 1;

  // Configuration registers
  logic vm_enabled;
  logic table_attached;

  // Captured input word
  logic                          act_q;
  logic [ptp_pkg::VADDR_W-1:0]   vaddr_q;
  logic [ptp_pkg::KIND_W-1:0]    kind_q;
  logic [ptp_pkg::SLOT_W-1:0]    slot_q;
  logic                          pres_q;
  logic [ptp_pkg::PN_W-1:0]      evpn_q;
  logic [ptp_pkg::PN_W-1:0]      eppn_q;
  logic [ptp_pkg::RIGHTS_W-1:0]  erights_q;

  // Slot table: VPNs in flops for the compare lanes, PPN and rights in memory
  logic [ptp_pkg::PN_W-1:0]      vpn_tab [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]      present;
  logic [TABLE_ENTRIES-1:0]      referenced;
  logic [TABLE_ENTRIES-1:0]      dirty;
  logic [ptp_pkg::PN_W-1:0]      ppn_mem    [TABLE_ENTRIES];
  logic [ptp_pkg::RIGHTS_W-1:0]  rights_mem [TABLE_ENTRIES];

  // Lookup pipeline registers
  logic [TABLE_ENTRIES-1:0]      match_q;
  logic                          hit_found;
  logic [IDX_W-1:0]              hit_idx;
  logic [ptp_pkg::PN_W-1:0]      ppn_rd;
  logic [ptp_pkg::RIGHTS_W-1:0]  rights_rd;

  // Output register
  logic                          out_valid;
  logic [ptp_pkg::VADDR_W-1:0]   out_paddr;
  logic [ptp_pkg::FAULT_W-1:0]   out_fault;
  logic                          out_ref;
  logic                          out_dirty;

  // Combinational helpers
  logic [CMP_W-1:0]              slot_ext;
  logic                          slot_in_range;
  logic [IDX_W-1:0]              wr_idx;
  logic [ptp_pkg::PN_W-1:0]      look_vpn;
  logic [IDX_W-1:0]              enc_idx;
  logic                          is_write;
  logic                          is_exec;
  logic                          is_read;
  ptp_pkg::fault_t               fault;
  logic                          hit_ok;
  logic [ptp_pkg::VADDR_W-1:0]   res_paddr;
  logic                          res_ref;
  logic                          res_dirty;

  // Handshake and status
  assign req.ready       = cmd.in_ready;
  assign cfg.ready       = 1'b1;
  assign status.in_valid = req.valid;
  assign status.out_free = !out_valid || rsp.ready;

  assign rsp.valid           = out_valid;
  assign rsp.paddr           = out_paddr;
  assign rsp.fault_code      = out_fault;
  assign rsp.referenced_mark = out_ref;
  assign rsp.dirty_mark      = out_dirty;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vm_enabled     <= 1'b0;
      table_attached <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ptp_pkg::CFG_VM_ENABLED:     vm_enabled     <= cfg.data;
        ptp_pkg::CFG_TABLE_ATTACHED: table_attached <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q     <= req.action;
      vaddr_q   <= req.vaddr;
      kind_q    <= req.access_kind;
      slot_q    <= req.slot;
      pres_q    <= req.entry_present;
      evpn_q    <= req.entry_vpn;
      eppn_q    <= req.entry_ppn;
      erights_q <= {req.can_execute, req.can_write, req.can_read, req.entry_valid};
    end
  end

  // Slot write address; slots past the table are dropped
  assign slot_ext      = CMP_W'(slot_q);
  assign slot_in_range = slot_ext < CMP_W'(TABLE_ENTRIES);
  assign wr_idx        = slot_ext[IDX_W-1:0];
  assign look_vpn      = vaddr_q[ptp_pkg::VADDR_W-1:ptp_pkg::OFF_W];

  // Compare lanes and slot write (match step)
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        match_q[i] <= present[i] && table_attached && (vpn_tab[i] == look_vpn);
      end
      if (act_q == ptp_pkg::ACT_WRITE && slot_in_range) begin
        vpn_tab[wr_idx]    <= evpn_q;
        ppn_mem[wr_idx]    <= eppn_q;
        rights_mem[wr_idx] <= erights_q;
      end
    end
  end

  // Lowest matching slot wins
  always_comb begin
    enc_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        enc_idx = IDX_W'(i);
      end
    end
  end

  // Select step: register hit and read the entry
  always_ff @(posedge clk) begin
    if (cmd.select) begin
      hit_found <= |match_q;
      hit_idx   <= enc_idx;
      ppn_rd    <= ppn_mem[enc_idx];
      rights_rd <= rights_mem[enc_idx];
    end
  end

  // Permission checks, in priority order
  assign is_write = (kind_q == ptp_pkg::ACC_WRITE);
  assign is_exec  = (kind_q == ptp_pkg::ACC_FETCH);
  assign is_read  = !is_write && !is_exec;

  always_comb begin
    if (!hit_found) begin
      fault = ptp_pkg::FAULT_NO_MAP;
    end else if (!rights_rd[ptp_pkg::RB_VALID]) begin
      fault = ptp_pkg::FAULT_INVALID;
    end else if (is_exec && !rights_rd[ptp_pkg::RB_EXEC]) begin
      fault = ptp_pkg::FAULT_EXEC;
    end else if (is_write && !rights_rd[ptp_pkg::RB_WRITE]) begin
      fault = ptp_pkg::FAULT_WRITE;
    end else if (is_read && !rights_rd[ptp_pkg::RB_READ]) begin
      fault = ptp_pkg::FAULT_READ;
    end else begin
      fault = ptp_pkg::FAULT_NONE;
    end
  end

  // Result word
  assign hit_ok = (act_q == ptp_pkg::ACT_TRANSLATE) && vm_enabled &&
                  (fault == ptp_pkg::FAULT_NONE);

  always_comb begin
    res_paddr = '0;
    res_ref   = 1'b0;
    res_dirty = 1'b0;
    if (act_q == ptp_pkg::ACT_TRANSLATE) begin
      if (!vm_enabled) begin
        res_paddr = vaddr_q;
      end else if (hit_ok) begin
        res_paddr = {ppn_rd, vaddr_q[ptp_pkg::OFF_W-1:0]};
        res_ref   = 1'b1;
        res_dirty = dirty[hit_idx] || is_write;
      end
    end
  end

  // Present, referenced and dirty marks
  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= '0;
      referenced <= '0;
      dirty      <= '0;
    end else begin
      if (cmd.match && act_q == ptp_pkg::ACT_WRITE && slot_in_range) begin
        present[wr_idx]    <= pres_q;
        referenced[wr_idx] <= 1'b0;
        dirty[wr_idx]      <= 1'b0;
      end
      if (cmd.finish && hit_ok) begin
        referenced[hit_idx] <= 1'b1;
        if (is_write) begin
          dirty[hit_idx] <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_paddr <= res_paddr;
      out_fault <= (act_q == ptp_pkg::ACT_TRANSLATE && vm_enabled) ?
                   fault : ptp_pkg::FAULT_NONE;
      out_ref   <= res_ref;
      out_dirty <= res_dirty;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/page_translation_with_permissions.sv =====
// Page translation with permissions: top level. Usage notes below.
// Depends on ptp_pkg, ptp_ifs, ptp_ctrl and ptp_datapath.
//
// Channels: req carries one word per item, either a translate (vaddr,
// access_kind) or a slot write (slot, entry fields). rsp returns exactly
// one word per item: paddr, fault_code and the referenced/dirty marks.
// cfg writes vm_enabled (index 0) and table_attached (index 1); it is
// always ready; write it only while the block is idle (not enforced).
// Steps: each item is captured, then all slots get the parallel VPN compare
// (and the slot write), then the lowest-hit select and the entry memory
// read run, then rights are checked, marks updated and the output register
// loaded. A new item is accepted only after the finish step of the last.
// Stall: a finished word waits in the output register while rsp.ready is
// low; the next item is still accepted and runs until its finish step,
// where it holds until the output register frees.
// Reset: clears all present, referenced and dirty marks, both config
// registers and the output valid; no clearing pass is needed.
`default_nettype none

module page_translation_with_permissions #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ptp_req_if.sink     req,
  ptp_rsp_if.source   rsp,
  ptp_cfg_if.sink     cfg
);

  ptp_pkg::ptp_cmd_t    cmd;
  ptp_pkg::ptp_status_t status;

  // Sequencer
  ptp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Table, checks and output register
  ptp_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule

`default_nettype wire

// ===== dv/ptp_checker.sv =====
// Scoreboard for the page translation block: watches the request, response
// and config channels, predicts each response word and compares it.
// Depends on ptp_pkg and ptp_ifs.
`timescale 1ns / 1ps

module ptp_checker #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  ptp_req_if        req,
  ptp_rsp_if        rsp,
  ptp_cfg_if        cfg,
  output int        errors,
  output int        outstanding
);

  typedef struct packed {
    logic [ptp_pkg::VADDR_W-1:0] paddr;
    ptp_pkg::fault_t             fault;
    logic                        referenced;
    logic                        dirty;
  } xlate_result_t;

  // Shadow copy of the config and page table
  logic                         vm_on;
  logic                         table_on;
  logic                         present    [TABLE_ENTRIES];
  logic [ptp_pkg::PN_W-1:0]     vpage      [TABLE_ENTRIES];
  logic [ptp_pkg::PN_W-1:0]     ppage      [TABLE_ENTRIES];
  logic [ptp_pkg::RIGHTS_W-1:0] rights     [TABLE_ENTRIES];
  logic                         referenced [TABLE_ENTRIES];
  logic                         dirty      [TABLE_ENTRIES];

  xlate_result_t pending_results [$];
  int            fails = 0;

  // Apply one request word to the shadow table and return its response
  function automatic xlate_result_t translate_word(
    input logic                         act,
    input logic [ptp_pkg::VADDR_W-1:0]  va,
    input logic [ptp_pkg::KIND_W-1:0]   kind,
    input logic [ptp_pkg::SLOT_W-1:0]   s,
    input logic                         pres,
    input logic [ptp_pkg::PN_W-1:0]     vpn,
    input logic [ptp_pkg::PN_W-1:0]     ppn,
    input logic [ptp_pkg::RIGHTS_W-1:0] rts
  );
    xlate_result_t                res;
    int                           hit;
    logic                         is_wr;
    logic                         is_fx;
    logic [ptp_pkg::PN_W-1:0]     page;
    logic [ptp_pkg::RIGHTS_W-1:0] r;
    res = '0;
    if (act == ptp_pkg::ACT_WRITE) begin
      // slot load: marks cleared, response all zero
      if (int'(s) < TABLE_ENTRIES) begin
        present[s]    = pres;
        vpage[s]      = vpn;
        ppage[s]      = ppn;
        rights[s]     = rts;
        referenced[s] = 1'b0;
        dirty[s]      = 1'b0;
      end
      return res;
    end
    if (!vm_on) begin
      res.paddr = va;
      return res;
    end
    // lowest present slot with a matching page wins
    hit  = -1;
    page = va[ptp_pkg::VADDR_W-1:ptp_pkg::OFF_W];
    if (table_on) begin
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (hit < 0 && present[i] && vpage[i] == page) hit = i;
    end
    is_wr = (kind == ptp_pkg::ACC_WRITE);
    is_fx = (kind == ptp_pkg::ACC_FETCH);
    if (hit < 0) begin
      res.fault = ptp_pkg::FAULT_NO_MAP;
    end else begin
      r = rights[hit];
      if (!r[ptp_pkg::RB_VALID])                   res.fault = ptp_pkg::FAULT_INVALID;
      else if (is_fx && !r[ptp_pkg::RB_EXEC])      res.fault = ptp_pkg::FAULT_EXEC;
      else if (is_wr && !r[ptp_pkg::RB_WRITE])     res.fault = ptp_pkg::FAULT_WRITE;
      else if (!is_wr && !is_fx && !r[ptp_pkg::RB_READ])
        res.fault = ptp_pkg::FAULT_READ;
      else begin
        referenced[hit] = 1'b1;
        if (is_wr) dirty[hit] = 1'b1;
        res.paddr      = {ppage[hit], va[ptp_pkg::OFF_W-1:0]};
        res.referenced = 1'b1;
        res.dirty      = dirty[hit];
      end
    end
    return res;
  endfunction

  // Sample all three channels on the clock edge
  always @(posedge clk) begin : watch
    xlate_result_t                want;
    logic [ptp_pkg::RIGHTS_W-1:0] rts;
    if (rst) begin
      vm_on    = 1'b0;
      table_on = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        present[i]    = 1'b0;
        referenced[i] = 1'b0;
        dirty[i]      = 1'b0;
      end
      pending_results.delete();
    end else begin
      // compare a returned word against the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("ptp_checker: response word with nothing expected");
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.paddr !== want.paddr) begin
            $error("paddr: expected %h, got %h", want.paddr, rsp.paddr);
            fails++;
          end
          if (rsp.fault_code !== want.fault) begin
            $error("fault_code: expected %0d, got %0d", want.fault, rsp.fault_code);
            fails++;
          end
          if (rsp.referenced_mark !== want.referenced) begin
            $error("referenced_mark: expected %b, got %b", want.referenced,
                   rsp.referenced_mark);
            fails++;
          end
          if (rsp.dirty_mark !== want.dirty) begin
            $error("dirty_mark: expected %b, got %b", want.dirty, rsp.dirty_mark);
            fails++;
          end
        end
      end
      // config writes land as seen; the bench must write them only while idle
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          ptp_pkg::CFG_VM_ENABLED:     vm_on    = cfg.data;
          ptp_pkg::CFG_TABLE_ATTACHED: table_on = cfg.data;
          default: ;
        endcase
      end
      // predict each accepted request word
      if (req.valid && req.ready) begin
        rts = '0;
        rts[ptp_pkg::RB_VALID] = req.entry_valid;
        rts[ptp_pkg::RB_READ]  = req.can_read;
        rts[ptp_pkg::RB_WRITE] = req.can_write;
        rts[ptp_pkg::RB_EXEC]  = req.can_execute;
        pending_results.push_back(translate_word(req.action, req.vaddr, req.access_kind,
                                                 req.slot, req.entry_present,
                                                 req.entry_vpn, req.entry_ppn, rts));
      end
    end
    errors      <= fails;
    outstanding <= pending_results.size();
  end

endmodule

// ===== dv/page_translation_with_permissions_tb.sv =====
// Testbench top for the page translation block: clock, reset, stimulus,
// response back-pressure and verdict. Depends on ptp_pkg, ptp_ifs, the
// block itself and ptp_checker.
`timescale 1ns / 1ps

module page_translation_with_permissions_tb;

  localparam int SLOTS       = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 194;
  localparam int HOLD_CYCLES = 80;
  localparam int HOT_PAGES   = 8;

  // Unused access kind, checked as a read
  localparam logic [ptp_pkg::KIND_W-1:0] ACC_OTHER = 2'd3;

  typedef struct packed {
    logic                        act;
    logic [ptp_pkg::VADDR_W-1:0] va;
    logic [ptp_pkg::KIND_W-1:0]  kind;
    logic [ptp_pkg::SLOT_W-1:0]  slot;
    logic                        pres;
    logic [ptp_pkg::PN_W-1:0]    vpn;
    logic [ptp_pkg::PN_W-1:0]    ppn;
    logic                        vbit;
    logic                        rd;
    logic                        wr;
    logic                        ex;
  } req_word_t;

  logic clk;
  logic rst = 1'b1;
  int   fails;
  int   in_flight;
  int   hold_asks = 0;
  int   holds_done = 0;
  int   burst_left = 0;
  logic [ptp_pkg::PN_W-1:0] hot [HOT_PAGES];

  ptp_req_if req ();
  ptp_rsp_if rsp ();
  ptp_cfg_if cfg ();

  page_translation_with_permissions #(.TABLE_ENTRIES(SLOTS)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  ptp_checker #(.TABLE_ENTRIES(SLOTS)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .errors      (fails),
    .outstanding (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("page_translation_with_permissions_tb: errors");
    $finish;
  end

  // Slot load word; the translate fields carry noise
  function automatic req_word_t slot_load_word(
    input logic [ptp_pkg::SLOT_W-1:0] s, input logic pres,
    input logic [ptp_pkg::PN_W-1:0] vpn, input logic [ptp_pkg::PN_W-1:0] ppn,
    input logic v, input logic r, input logic w, input logic x
  );
    req_word_t wd;
    wd      = '{default: '0};
    wd.act  = ptp_pkg::ACT_WRITE;
    wd.va   = $urandom;
    wd.kind = ptp_pkg::KIND_W'($urandom);
    wd.slot = s;
    wd.pres = pres;
    wd.vpn  = vpn;
    wd.ppn  = ppn;
    wd.vbit = v;
    wd.rd   = r;
    wd.wr   = w;
    wd.ex   = x;
    return wd;
  endfunction

  // Translate word; the slot fields carry noise
  function automatic req_word_t lookup_word(
    input logic [ptp_pkg::VADDR_W-1:0] va, input logic [ptp_pkg::KIND_W-1:0] kind
  );
    req_word_t wd;
    wd      = slot_load_word(ptp_pkg::SLOT_W'($urandom), 1'($urandom),
                             ptp_pkg::PN_W'($urandom), ptp_pkg::PN_W'($urandom),
                             1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    wd.act  = ptp_pkg::ACT_TRANSLATE;
    wd.va   = va;
    wd.kind = kind;
    return wd;
  endfunction

  // Random word biased toward a small set of pages so lookups hit
  function automatic req_word_t random_word();
    logic [ptp_pkg::PN_W-1:0] pg;
    pg = ($urandom_range(0, 99) < 85) ? hot[$urandom_range(0, HOT_PAGES-1)]
                                      : ptp_pkg::PN_W'($urandom);
    if ($urandom_range(0, 99) < 25)
      return slot_load_word(ptp_pkg::SLOT_W'($urandom), $urandom_range(0, 99) < 88, pg,
                            ptp_pkg::PN_W'($urandom), $urandom_range(0, 99) < 85,
                            1'($urandom), 1'($urandom), 1'($urandom));
    return lookup_word({pg, ptp_pkg::OFF_W'($urandom)}, ptp_pkg::KIND_W'($urandom));
  endfunction

  // Offer one word; bursts of random length with random gaps between
  task automatic send_word(input req_word_t wd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid         <= 1'b1;
    req.action        <= wd.act;
    req.vaddr         <= wd.va;
    req.access_kind   <= wd.kind;
    req.slot          <= wd.slot;
    req.entry_present <= wd.pres;
    req.entry_vpn     <= wd.vpn;
    req.entry_ppn     <= wd.ppn;
    req.entry_valid   <= wd.vbit;
    req.can_read      <= wd.rd;
    req.can_write     <= wd.wr;
    req.can_execute   <= wd.ex;
    do @(posedge clk); while (!req.ready);
  endtask

  // Stop offering and wait until every predicted word has returned
  task automatic settle();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (in_flight != 0);
    repeat (8) @(posedge clk);
  endtask

  // Write both config registers back to back
  task automatic set_config(input logic vm, input logic ta);
    cfg.valid <= 1'b1;
    cfg.index <= ptp_pkg::CFG_VM_ENABLED;
    cfg.data  <= vm;
    do @(posedge clk); while (!cfg.ready);
    cfg.index <= ptp_pkg::CFG_TABLE_ATTACHED;
    cfg.data  <= ta;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // Response side: segments of random ready density, plus long holds on request
  initial begin : receiver
    int seg;
    int pct;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      seg = $urandom_range(4, 40);
      case ($urandom_range(0, 3))
        0, 1:    pct = 100;
        2:       pct = 60;
        default: pct = 25;
      endcase
      repeat (seg) begin
        if (holds_done != hold_asks) begin
          rsp.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          holds_done++;
        end
        rsp.ready <= ($urandom_range(1, 100) <= pct);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic vm;
    logic ta;
    req.valid         <= 1'b0;
    req.action        <= ptp_pkg::ACT_TRANSLATE;
    req.vaddr         <= '0;
    req.access_kind   <= ptp_pkg::ACC_READ;
    req.slot          <= '0;
    req.entry_present <= 1'b0;
    req.entry_vpn     <= '0;
    req.entry_ppn     <= '0;
    req.entry_valid   <= 1'b0;
    req.can_read      <= 1'b0;
    req.can_write     <= 1'b0;
    req.can_execute   <= 1'b0;
    cfg.valid         <= 1'b0;
    cfg.index         <= ptp_pkg::CFG_VM_ENABLED;
    cfg.data          <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // VM off after reset: addresses pass straight through
    send_word(lookup_word(32'h0000_0000, ptp_pkg::ACC_READ));
    send_word(lookup_word(32'hFFFF_FFFF, ACC_OTHER));
    // table contents loaded while VM is off
    send_word(slot_load_word(4'd0,  1'b1, 20'h00000, 20'hFFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(slot_load_word(4'd15, 1'b1, 20'hFFFFF, 20'h00000, 1'b1, 1'b1, 1'b0, 1'b0));
    send_word(slot_load_word(4'd3,  1'b1, 20'h00123, 20'h00ABC, 1'b0, 1'b1, 1'b1, 1'b1));
    send_word(slot_load_word(4'd4,  1'b1, 20'h00200, 20'h11111, 1'b1, 1'b1, 1'b1, 1'b0));
    send_word(slot_load_word(4'd5,  1'b1, 20'h00300, 20'h22222, 1'b1, 1'b0, 1'b0, 1'b1));
    // duplicate page in slots 6 and 7
    send_word(slot_load_word(4'd6,  1'b1, 20'h00400, 20'h33333, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(slot_load_word(4'd7,  1'b1, 20'h00400, 20'h44444, 1'b1, 1'b1, 1'b1, 1'b1));
    // loaded but not present
    send_word(slot_load_word(4'd8,  1'b0, 20'h00500, 20'h55555, 1'b1, 1'b1, 1'b1, 1'b1));
    settle();

    // VM on, table detached: every lookup misses
    set_config(1'b1, 1'b0);
    send_word(lookup_word(32'h0000_0000, ptp_pkg::ACC_READ));
    settle();

    // VM on, table attached: every fault path and the mark updates
    set_config(1'b1, 1'b1);
    send_word(lookup_word(32'h0000_0000, ptp_pkg::ACC_READ));
    send_word(lookup_word(32'h0000_0FFF, ptp_pkg::ACC_WRITE));
    send_word(lookup_word(32'hFFFF_F000, ptp_pkg::ACC_FETCH));
    send_word(lookup_word(32'hFFFF_FFFF, ptp_pkg::ACC_WRITE));
    send_word(lookup_word(32'hFFFF_F7A5, ptp_pkg::ACC_READ));
    send_word(lookup_word(32'h0012_3456, ptp_pkg::ACC_READ));
    send_word(lookup_word(32'h0020_0010, ptp_pkg::ACC_FETCH));
    send_word(lookup_word(32'h0030_0004, ACC_OTHER));
    send_word(lookup_word(32'h0030_0004, ptp_pkg::ACC_WRITE));
    send_word(lookup_word(32'h0030_0ABC, ptp_pkg::ACC_FETCH));
    send_word(lookup_word(32'h0040_0800, ptp_pkg::ACC_READ));
    send_word(lookup_word(32'h0050_0000, ptp_pkg::ACC_READ));
    send_word(lookup_word(32'h0099_9000, ptp_pkg::ACC_READ));
    // reload clears the marks of slot 0
    send_word(slot_load_word(4'd0, 1'b1, 20'h00000, 20'hFFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
    send_word(lookup_word(32'h0000_0123, ptp_pkg::ACC_READ));
    settle();

    // VM off with live mappings: still a pass-through
    set_config(1'b0, 1'b1);
    send_word(lookup_word(32'h0040_0800, ptp_pkg::ACC_WRITE));
    settle();

    // Random phases across all config settings
    hot[0] = '0;
    hot[1] = '1;
    for (int p = 0; p < PHASES; p++) begin
      vm = !(p == 2 || p == 6);
      ta = !(p == 4 || p == 6);
      set_config(vm, ta);
      for (int k = 2; k < HOT_PAGES; k++) hot[k] = ptp_pkg::PN_W'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long response hold while requests keep coming
        if ((p == 1 || p == 5) && n == 20) hold_asks++;
        if (p == 3 && n == 100) settle();
        send_word(random_word());
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (fails == 0 && in_flight == 0)
      $display("page_translation_with_permissions_tb: clean");
    else
      $display("page_translation_with_permissions_tb: errors");
    $finish;
  end

endmodule
